### rtl/dchtm_pkg.sv
// Shared types and constants of the device-clock to host-time mapper.
// Used by the channel interfaces, the controller, the datapath and the top level.
package dchtm_pkg;

   // Field widths
   localparam int DEV_W   = 32;   // device millisecond stamp
   localparam int NS_W    = 63;   // host nanosecond time
   localparam int RATE_W  = 32;   // unsigned fixed-point rate
   localparam int WIN_W   = 16;   // calibration window register
   localparam int BLEND_W = 16;   // Q0.16 blend weight
   localparam int CFG_W   = 32;   // widest configuration register
   localparam int CSR_IDX_W = 2;

   // Arithmetic widths
   localparam int MUL_W     = 64;              // shared 32x32 multiplier product
   localparam int DEN_W     = 52;              // 32-bit count times 1e6
   localparam int OBS_W     = 32;              // quotient bits of the observed rate
   localparam int AHI_W     = DEN_W - OBS_W;   // upper part of delta * 1e6
   localparam int ACC_W     = DEN_W + OBS_W;   // full delta_ns * rate product
   localparam int DIV_EXT_W = NS_W + OBS_W;    // numerator shifted by the fraction bits
   localparam int CNT_W     = $clog2(OBS_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OBS_W - 1);

   localparam logic [RATE_W-1:0]  NS_PER_MS  = 32'd1000000;
   localparam logic [BLEND_W:0]   BLEND_ONE  = 17'h10000;

   // Reset values of the registers
   localparam logic [WIN_W-1:0]   WINDOW_RST   = 16'd1000;
   localparam logic [BLEND_W-1:0] BLEND_RST    = 16'd6554;
   localparam logic [RATE_W-1:0]  MIN_RATE_RST = 32'd966367642;
   localparam logic [RATE_W-1:0]  MAX_RATE_RST = 32'd1181116006;

   // Defaults of the top-level parameters
   localparam logic [DEV_W-1:0] HALF_RANGE_DEF     = 32'h8000_0000;
   localparam int               RATE_FRAC_BITS_DEF = 30;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW   = 2'd0,
      CSR_BLEND    = 2'd1,
      CSR_MIN_RATE = 2'd2,
      CSR_MAX_RATE = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_CALCHK,
      ST_DEN,
      ST_DIVINIT,
      ST_DIVRUN,
      ST_MIX0,
      ST_MIX1,
      ST_MIXADD,
      ST_CLAMP,
      ST_STEPA,
      ST_STEPLO,
      ST_STEPHI,
      ST_STEPADD,
      ST_MAP
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_DEN,      // accum * 1e6
      MUL_MIXOLD,   // (1 - blend) * rate
      MUL_MIXNEW,   // blend * observed
      MUL_STEPA,    // delta * 1e6
      MUL_STEPLO,   // low word of delta_ns * rate
      MUL_STEPHI    // high part of delta_ns * rate
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD_LO,
      ACC_ADD_HI
   } acc_op_type;

   typedef struct packed {
      logic        take_req;
      logic        decide_commit;
      logic        calib_commit;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        div_init;
      logic        div_step;
      logic        rate_commit;
      logic        map_commit;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic reanchor;
      logic zero_delta;
      logic calib_due;
      logic rate_due;
      logic obs_sat;
   } status_type;

endpackage

### rtl/dchtm_if.sv
// Valid/ready channel interfaces of the time mapper: stamp requests and mapped responses.
// Depends on dchtm_pkg for the field widths.
interface dchtm_req_if;
   import dchtm_pkg::*;

   logic             valid;
   logic             ready;
   logic [DEV_W-1:0] device_time_ms;
   logic [NS_W-1:0]  host_arrival_ns;

   modport source (output valid, output device_time_ms, output host_arrival_ns, input ready);
   modport sink   (input valid, input device_time_ms, input host_arrival_ns, output ready);
endinterface

interface dchtm_rsp_if;
   import dchtm_pkg::*;

   logic            valid;
   logic            ready;
   logic [NS_W-1:0] mapped_host_ns;
   logic            reanchored;

   modport source (output valid, output mapped_host_ns, output reanchored, input ready);
   modport sink   (input valid, input mapped_host_ns, input reanchored, output ready);
endinterface

### rtl/dchtm_ctrl.sv
// Sequencer of the time mapper: walks each request through decide, calibrate and map steps.
// Depends on dchtm_pkg; drives the datapath through cmd_type and reads status_type.
module dchtm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dchtm_pkg::status_type status,
   output dchtm_pkg::cmd_type    cmd
);
   import dchtm_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               if (status.reanchor || status.zero_delta) state_in = ST_IDLE;
               else state_in = ST_CALCHK;
            end
         end
         ST_CALCHK: begin
            if (status.calib_due && status.rate_due) state_in = ST_DEN;
            else state_in = ST_STEPA;
         end
         ST_DEN:     state_in = ST_DIVINIT;
         ST_DIVINIT: begin
            if (status.obs_sat) state_in = ST_MIX0;
            else state_in = ST_DIVRUN;
         end
         ST_DIVRUN: begin
            if (cnt_ff == CNT_LAST) state_in = ST_MIX0;
         end
         ST_MIX0:    state_in = ST_MIX1;
         ST_MIX1:    state_in = ST_MIXADD;
         ST_MIXADD:  state_in = ST_CLAMP;
         ST_CLAMP:   state_in = ST_STEPA;
         ST_STEPA:   state_in = ST_STEPLO;
         ST_STEPLO:  state_in = ST_STEPHI;
         ST_STEPHI:  state_in = ST_STEPADD;
         ST_STEPADD: state_in = ST_MAP;
         ST_MAP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd               = '0;
      cmd.mul_sel       = MUL_NONE;
      cmd.acc_op        = ACC_HOLD;
      cnt_in            = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take_req = req_valid;
         end
         ST_DECIDE: begin
            // hold every update until the response register can take a result
            cmd.decide_commit = rsp_free;
            cmd.rsp_load      = rsp_free && (status.reanchor || status.zero_delta);
         end
         ST_CALCHK: begin
            cmd.calib_commit = status.calib_due;
         end
         ST_DEN: begin
            cmd.mul_sel = MUL_DEN;
         end
         ST_DIVINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
         end
         ST_DIVRUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
         end
         ST_MIX0: begin
            cmd.mul_sel = MUL_MIXOLD;
         end
         ST_MIX1: begin
            cmd.mul_sel = MUL_MIXNEW;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_MIXADD: begin
            cmd.acc_op = ACC_ADD_LO;
         end
         ST_CLAMP: begin
            cmd.rate_commit = 1'b1;
         end
         ST_STEPA: begin
            cmd.mul_sel = MUL_STEPA;
         end
         ST_STEPLO: begin
            cmd.mul_sel = MUL_STEPLO;
         end
         ST_STEPHI: begin
            cmd.mul_sel = MUL_STEPHI;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_STEPADD: begin
            cmd.acc_op = ACC_ADD_HI;
         end
         ST_MAP: begin
            cmd.map_commit = rsp_free;
            cmd.rsp_load   = rsp_free;
         end
         default: begin
            cmd.take_req = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   a_div_runs_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVRUN && cnt_ff != CNT_LAST) |=> state_ff == ST_DIVRUN)
      else $error("divider left before all quotient bits were formed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded over an untaken result");

endmodule

### rtl/dchtm_dp.sv
// Datapath of the time mapper: mapping state, registers, shared multiplier,
// accumulator and a one-bit-per-cycle divider. Depends on dchtm_pkg.
module dchtm_dp #(
   parameter logic [dchtm_pkg::DEV_W-1:0] HALF_RANGE     = dchtm_pkg::HALF_RANGE_DEF,
   parameter int                          RATE_FRAC_BITS = dchtm_pkg::RATE_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dchtm_pkg::cmd_type              cmd,
   output dchtm_pkg::status_type           status,
   input  logic [dchtm_pkg::DEV_W-1:0]     req_device_time_ms,
   input  logic [dchtm_pkg::NS_W-1:0]      req_host_arrival_ns,
   output logic [dchtm_pkg::NS_W-1:0]      rsp_mapped_host_ns,
   output logic                            rsp_reanchored,
   input  logic                            csr_we,
   input  dchtm_pkg::csr_index_type        csr_index,
   input  logic [dchtm_pkg::CFG_W-1:0]     csr_wdata
);
   import dchtm_pkg::*;

   localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(64'd1 << RATE_FRAC_BITS);
   localparam int                SAT_SH   = OBS_W - RATE_FRAC_BITS;

   // configuration
   logic [WIN_W-1:0]   window_ff;
   logic [BLEND_W-1:0] blend_ff;
   logic [RATE_W-1:0]  min_rate_ff, max_rate_ff;

   // mapping state
   logic               anchored_ff, anchored_in;
   logic [DEV_W-1:0]   prev_dev_ff, prev_dev_in;
   logic [NS_W-1:0]    prev_map_ff, prev_map_in;
   logic [NS_W-1:0]    anchor_ff, anchor_in;
   logic [DEV_W-1:0]   accum_ff, accum_in;
   logic [DEV_W-1:0]   next_calib_ff, next_calib_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;

   // working registers
   logic [DEV_W-1:0]   dev_ff;
   logic [NS_W-1:0]    arr_ff;
   logic [NS_W-1:0]    num_ff, gap_ff;
   logic               host_ahead_ff, behind_ff;
   logic [MUL_W-1:0]   mul_ff;
   logic [AHI_W-1:0]   ahi_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [OBS_W-1:0]   quo_ff, quo_in;
   logic [NS_W-1:0]    rsp_ns_ff;
   logic               rsp_re_ff;

   logic [DEV_W-1:0]     delta;
   logic [NS_W-1:0]      zero_map;
   logic [RATE_W-1:0]    mul_a, mul_b;
   logic [DEN_W-1:0]     den;
   logic [DIV_EXT_W-1:0] div_ext;
   logic [DEN_W:0]       trial;
   logic                 trial_ge;
   logic [RATE_W-1:0]    mix_rate, clamp_lo, clamp_rate;
   logic [ACC_W-1:0]     step_ns;
   logic [NS_W-1:0]      mapped;

   assign delta    = dev_ff - prev_dev_ff;
   assign zero_map = (arr_ff < prev_map_ff) ? arr_ff : prev_map_ff;
   assign den      = mul_ff[DEN_W-1:0];

   assign status.reanchor   = !anchored_ff || (delta >= HALF_RANGE);
   assign status.zero_delta = (delta == '0);
   assign status.calib_due  = (accum_ff >= next_calib_ff);
   assign status.rate_due   = host_ahead_ff && (accum_ff != '0);
   // quotient would not fit 32 bits: num * 2^F >= den * 2^32
   assign status.obs_sat    = ACC_W'(num_ff) >= (ACC_W'(den) << SAT_SH);

   // divider
   assign div_ext  = DIV_EXT_W'(num_ff) << RATE_FRAC_BITS;
   assign trial    = {rem_ff, quo_ff[OBS_W-1]};
   assign trial_ge = trial >= {1'b0, den};

   // blend and clamp
   assign mix_rate   = acc_ff[BLEND_W +: RATE_W];
   assign clamp_lo   = (mix_rate < min_rate_ff) ? min_rate_ff : mix_rate;
   assign clamp_rate = (clamp_lo > max_rate_ff) ? max_rate_ff : clamp_lo;

   // map step; cap at the arrival time
   assign step_ns = acc_ff >> RATE_FRAC_BITS;
   assign mapped  = (behind_ff || step_ns >= ACC_W'(gap_ff)) ? arr_ff
                                                             : prev_map_ff + step_ns[NS_W-1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_DEN: begin
            mul_a = accum_ff;
            mul_b = NS_PER_MS;
         end
         MUL_MIXOLD: begin
            mul_a = RATE_W'(BLEND_ONE - {1'b0, blend_ff});
            mul_b = rate_ff;
         end
         MUL_MIXNEW: begin
            mul_a = RATE_W'(blend_ff);
            mul_b = quo_ff;
         end
         MUL_STEPA: begin
            mul_a = delta;
            mul_b = NS_PER_MS;
         end
         MUL_STEPLO: begin
            mul_a = mul_ff[OBS_W-1:0];
            mul_b = rate_ff;
         end
         MUL_STEPHI: begin
            mul_a = RATE_W'(ahi_ff);
            mul_b = rate_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      case (cmd.acc_op)
         ACC_LOAD:   acc_in = ACC_W'(mul_ff);
         ACC_ADD_LO: acc_in = acc_ff + ACC_W'(mul_ff);
         ACC_ADD_HI: acc_in = acc_ff + {mul_ff[DEN_W-1:0], {OBS_W{1'b0}}};
         default:    acc_in = acc_ff;
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_init) begin
         rem_in = div_ext[OBS_W +: DEN_W];
         quo_in = status.obs_sat ? '1 : div_ext[OBS_W-1:0];
      end else if (cmd.div_step) begin
         rem_in = trial_ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[OBS_W-2:0], trial_ge};
      end
   end

   always_comb begin
      anchored_in   = anchored_ff;
      prev_dev_in   = prev_dev_ff;
      prev_map_in   = prev_map_ff;
      anchor_in     = anchor_ff;
      accum_in      = accum_ff;
      next_calib_in = next_calib_ff;
      rate_in       = rate_ff;
      if (cmd.decide_commit) begin
         if (status.reanchor) begin
            anchored_in   = 1'b1;
            prev_dev_in   = dev_ff;
            prev_map_in   = arr_ff;
            anchor_in     = arr_ff;
            accum_in      = '0;
            next_calib_in = DEV_W'(window_ff);
            rate_in       = RATE_ONE;
         end else if (status.zero_delta) begin
            prev_map_in = zero_map;
         end else begin
            accum_in = accum_ff + delta;
         end
      end
      if (cmd.calib_commit) next_calib_in = accum_ff + DEV_W'(window_ff);
      if (cmd.rate_commit) rate_in = clamp_rate;
      if (cmd.map_commit) begin
         prev_dev_in = dev_ff;
         prev_map_in = mapped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= WINDOW_RST;
         blend_ff      <= BLEND_RST;
         min_rate_ff   <= MIN_RATE_RST;
         max_rate_ff   <= MAX_RATE_RST;
         anchored_ff   <= 1'b0;
         prev_dev_ff   <= '0;
         prev_map_ff   <= '0;
         anchor_ff     <= '0;
         accum_ff      <= '0;
         next_calib_ff <= DEV_W'(WINDOW_RST);
         rate_ff       <= RATE_ONE;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_WINDOW:   window_ff   <= csr_wdata[WIN_W-1:0];
               CSR_BLEND:    blend_ff    <= csr_wdata[BLEND_W-1:0];
               CSR_MIN_RATE: min_rate_ff <= csr_wdata[RATE_W-1:0];
               CSR_MAX_RATE: max_rate_ff <= csr_wdata[RATE_W-1:0];
               default:      window_ff   <= window_ff;
            endcase
         end
         anchored_ff   <= anchored_in;
         prev_dev_ff   <= prev_dev_in;
         prev_map_ff   <= prev_map_in;
         anchor_ff     <= anchor_in;
         accum_ff      <= accum_in;
         next_calib_ff <= next_calib_in;
         rate_ff       <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         dev_ff <= req_device_time_ms;
         arr_ff <= req_host_arrival_ns;
      end
      if (cmd.decide_commit) begin
         num_ff        <= arr_ff - anchor_ff;
         host_ahead_ff <= arr_ff > anchor_ff;
         gap_ff        <= arr_ff - prev_map_ff;
         behind_ff     <= prev_map_ff >= arr_ff;
      end
      if (cmd.mul_sel != MUL_NONE) mul_ff <= mul_a * mul_b;
      if (cmd.mul_sel == MUL_STEPLO) ahi_ff <= mul_ff[DEN_W-1:OBS_W];
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.rsp_load) begin
         if (cmd.map_commit) begin
            rsp_ns_ff <= mapped;
            rsp_re_ff <= 1'b0;
         end else if (status.reanchor) begin
            rsp_ns_ff <= arr_ff;
            rsp_re_ff <= 1'b1;
         end else begin
            rsp_ns_ff <= zero_map;
            rsp_re_ff <= 1'b0;
         end
      end
   end

   assign rsp_mapped_host_ns = rsp_ns_ff;
   assign rsp_reanchored     = rsp_re_ff;

   a_rate_clamped: assert property (@(posedge clock) disable iff (reset)
      (cmd.rate_commit && min_rate_ff <= max_rate_ff) |=>
         (rate_ff >= $past(min_rate_ff) && rate_ff <= $past(max_rate_ff)))
      else $error("recalibrated rate outside its clamps");

   a_map_capped: assert property (@(posedge clock) disable iff (reset)
      cmd.map_commit |=> prev_map_ff <= $past(arr_ff))
      else $error("mapped time passed the arrival time");

endmodule

### rtl/device_clock_to_host_time_mapper.sv
// Device clock to host time mapper. Each request carries a 32-bit device millisecond
// stamp and its host arrival time in ns; one response gives the estimated host time of
// the stamp. The first request after reset, or a device step of at least HALF_RANGE
// (modulo 2^32), restarts the mapping and returns the arrival time with reanchored set.
// Otherwise the mapped time advances by delta_ms * 1e6 * rate, never past the arrival
// time; the Q2.30 rate is recalibrated from the host/device progress since the anchor
// once per calibration window, blended with the Q0.16 weight and clamped to
// [min_rate, max_rate]. Requests are handled one at a time. A restart or a repeated
// stamp is answered at the decide step; an ordinary step then runs the map multiplies;
// a step that recalibrates first runs the restoring divider, which forms one of the 32
// quotient bits per cycle, unless the observed rate saturates. The response register
// lets the next request be accepted while a result waits; a waiting result stalls the
// following request at its first step. Write configuration only while idle.
module device_clock_to_host_time_mapper #(
   parameter logic [dchtm_pkg::DEV_W-1:0] HALF_RANGE     = dchtm_pkg::HALF_RANGE_DEF,
   parameter int                          RATE_FRAC_BITS = dchtm_pkg::RATE_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   dchtm_req_if.sink                   req_if,
   dchtm_rsp_if.source                 rsp_if,
   input  logic                        csr_we,
   input  dchtm_pkg::csr_index_type    csr_index,
   input  logic [dchtm_pkg::CFG_W-1:0] csr_wdata
);
   import dchtm_pkg::*;

   cmd_type    cmd;
   status_type status;

   dchtm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dchtm_dp #(
      .HALF_RANGE     (HALF_RANGE),
      .RATE_FRAC_BITS (RATE_FRAC_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_device_time_ms  (req_if.device_time_ms),
      .req_host_arrival_ns (req_if.host_arrival_ns),
      .rsp_mapped_host_ns  (rsp_if.mapped_host_ns),
      .rsp_reanchored      (rsp_if.reanchored),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

endmodule

### bench/device_clock_to_host_time_mapper_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for device_clock_to_host_time_mapper: a scoreboard class predicts each
// mapped host time from accepted stamps; plain tasks drive stamps and register writes.
// Depends on dchtm_pkg and the dchtm_req_if / dchtm_rsp_if channel interfaces.
module device_clock_to_host_time_mapper_tb;
   import dchtm_pkg::*;

   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned PHASE_ITEMS  = 88;
   localparam int unsigned PHASE_COUNT  = 6;
   localparam int unsigned DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [NS_W-1:0] mapped_ns;
      logic            reanchored;
   } mapped_result_type;

   class mapping_scoreboard_type;
      // register copies
      logic [31:0] window;
      logic [31:0] blend;
      logic [31:0] rate_lo;
      logic [31:0] rate_hi;
      // mapping state
      bit          anchored;
      logic [31:0] last_dev;
      logic [63:0] last_mapped;
      logic [63:0] anchor_ns;
      logic [31:0] elapsed_ms;
      logic [31:0] calib_point;
      logic [31:0] rate;
      mapped_result_type expected_maps[$];
      int unsigned errors;
      int unsigned stamps;
      int unsigned restarts;
      int unsigned recalibrations;

      function new();
         window         = 32'(WINDOW_RST);
         blend          = 32'(BLEND_RST);
         rate_lo        = MIN_RATE_RST;
         rate_hi        = MAX_RATE_RST;
         anchored       = 1'b0;
         last_dev       = '0;
         last_mapped    = '0;
         anchor_ns      = '0;
         elapsed_ms     = '0;
         calib_point    = window;
         rate           = 32'(1) << RATE_FRAC_BITS_DEF;
         errors         = 0;
         stamps         = 0;
         restarts       = 0;
         recalibrations = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_WINDOW:   window  = {16'd0, value[15:0]};
            CSR_BLEND:    blend   = {16'd0, value[15:0]};
            CSR_MIN_RATE: rate_lo = value;
            CSR_MAX_RATE: rate_hi = value;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_maps.size();
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("%0t mismatch %0d: %s got 0x%0h expected 0x%0h", $realtime, errors, what,
                  got, want);
      endtask

      function void note_request(logic [DEV_W-1:0] dev, logic [NS_W-1:0] arr);
         logic [31:0]    delta;
         logic [63:0]    arrival;
         logic [63:0]    step_ns;
         logic [63:0]    mapped;
         logic [127:0]   quot;
         logic [127:0]   prod;
         logic [31:0]    observed;
         logic [63:0]    mix;
         logic [31:0]    blended;
         mapped_result_type res;
         arrival = {1'b0, arr};
         delta   = dev - last_dev;
         stamps++;
         if (!anchored || delta >= HALF_RANGE_DEF) begin
            anchored    = 1'b1;
            last_dev    = dev;
            last_mapped = arrival;
            anchor_ns   = arrival;
            elapsed_ms  = '0;
            calib_point = window;
            rate        = 32'(1) << RATE_FRAC_BITS_DEF;
            res.mapped_ns  = arr;
            res.reanchored = 1'b1;
            restarts++;
         end else if (delta == 32'd0) begin
            if (arrival < last_mapped) last_mapped = arrival;
            res.mapped_ns  = last_mapped[NS_W-1:0];
            res.reanchored = 1'b0;
         end else begin
            elapsed_ms += delta;
            if (elapsed_ms >= calib_point) begin
               recalibrations++;
               // hold the rate when the host has not moved past the anchor or no time has accumulated
               if (arrival > anchor_ns && elapsed_ms != 32'd0) begin
                  quot = ({64'd0, arrival - anchor_ns} << RATE_FRAC_BITS_DEF) /
                         (128'(elapsed_ms) * 128'(NS_PER_MS));
                  observed = (quot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
                  mix = 64'(17'h10000 - {1'b0, blend[15:0]}) * 64'(rate) +
                        64'(blend) * 64'(observed);
                  blended = mix[47:16];
                  if (blended < rate_lo) blended = rate_lo;
                  if (blended > rate_hi) blended = rate_hi;
                  rate = blended;
               end
               calib_point = elapsed_ms + window;
            end
            prod = (128'(64'(delta) * 64'(NS_PER_MS)) * 128'(rate)) >> RATE_FRAC_BITS_DEF;
            step_ns = (prod > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
            // never run past the arrival time
            if (last_mapped >= arrival || step_ns >= arrival - last_mapped) mapped = arrival;
            else mapped = last_mapped + step_ns;
            last_dev    = dev;
            last_mapped = mapped;
            res.mapped_ns  = mapped[NS_W-1:0];
            res.reanchored = 1'b0;
         end
         expected_maps.push_back(res);
      endfunction

      task check_response(logic [NS_W-1:0] mapped_ns, logic reanchored);
         mapped_result_type want;
         if (expected_maps.size() == 0) begin
            report_mismatch("response with no stamp outstanding", 64'(mapped_ns), 64'd0);
            return;
         end
         want = expected_maps.pop_front();
         if (mapped_ns !== want.mapped_ns)
            report_mismatch("mapped_host_ns", 64'(mapped_ns), 64'(want.mapped_ns));
         if (reanchored !== want.reanchored)
            report_mismatch("reanchored", 64'(reanchored), 64'(want.reanchored));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [CFG_W-1:0]    csr_wdata;

   dchtm_req_if req_bus ();
   dchtm_rsp_if rsp_bus ();

   device_clock_to_host_time_mapper dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mapping_scoreboard_type sb;

   // stimulus bookkeeping
   logic [31:0]  cur_dev;
   logic [63:0]  cur_arr;
   int unsigned  cur_window;
   int unsigned  settings;
   bit           src_idling;
   bit           sink_idling;
   bit           sink_hold_req;
   int unsigned  sink_stall;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      sink_stall = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            if (sink_stall == 0 && sink_hold_req) begin
               sink_hold_req = 1'b0;
               sink_stall    = HOLD_CYCLES;
            end else if (sink_stall == 0 && sink_idling && $urandom_range(0, 9) == 0) begin
               sink_stall = $urandom_range(1, 16);
            end
            if (sink_stall != 0) begin
               rsp_bus.ready <= 1'b0;
               sink_stall--;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // check results before noting stamps accepted at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.mapped_host_ns, rsp_bus.reanchored);
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.device_time_ms, req_bus.host_arrival_ns);
      end
   end

   task automatic send_stamp(input logic [31:0] dev, input logic [62:0] arr);
      int unsigned gap;
      req_bus.valid           <= 1'b1;
      req_bus.device_time_ms  <= dev;
      req_bus.host_arrival_ns <= arr;
      do @(posedge clock); while (!req_bus.ready);
      cur_dev = dev;
      cur_arr = {1'b0, arr};
      if (src_idling && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 16);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic program_settings(input logic [31:0] win, input logic [31:0] blend,
                                   input logic [31:0] lo, input logic [31:0] hi);
      csr_index_type order [4];
      logic [31:0]   vals [4];
      order = '{CSR_WINDOW, CSR_BLEND, CSR_MIN_RATE, CSR_MAX_RATE};
      vals  = '{win, blend, lo, hi};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         sb.set_register(order[i], vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cur_window = 32'(win[15:0]);
      settings++;
   endtask

   task automatic random_settings();
      logic [31:0] win;
      logic [31:0] blend;
      logic [31:0] lo;
      logic [31:0] hi;
      case ($urandom_range(0, 7))
         0:       win = 32'd0;
         1:       win = 32'd1;
         2:       win = 32'd65535;
         default: win = $urandom_range(1, 3000);
      endcase
      win[31:16] = 16'($urandom_range(0, 65535));
      blend      = $urandom;
      if ($urandom_range(0, 4) == 0) begin
         lo = $urandom;
         hi = $urandom;
      end else begin
         lo = $urandom_range(32'h3000_0000, 32'h4000_0000);
         hi = $urandom_range(32'h4000_0000, 32'h5000_0000);
      end
      program_settings(win, blend, lo, hi);
   endtask

   task automatic random_item();
      int unsigned pick;
      int unsigned k;
      int unsigned jitter;
      logic [31:0] delta;
      logic [31:0] dev;
      logic [63:0] arr;
      pick = $urandom_range(0, 99);
      dev  = cur_dev;
      arr  = cur_arr;
      if (pick < 68) begin
         // well-formed step near unit rate, sometimes far off
         delta = $urandom_range(1, (cur_window < 32) ? 32 : cur_window / 2 + 1);
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4000) : $urandom_range(900, 1150);
         dev = cur_dev + delta;
         arr = cur_arr + ((64'(delta) * 64'd1_000_000 * 64'(k)) >> 10);
         if ($urandom_range(0, 7) == 0) arr = arr - 64'($urandom_range(0, 2_000_000));
      end else if (pick < 78) begin
         jitter = $urandom_range(0, 3_000_000);
         arr = ($urandom_range(0, 1) == 1) ? cur_arr + 64'(jitter) : cur_arr - 64'(jitter);
      end else if (pick < 84) begin
         dev = cur_dev - $urandom_range(1, 5000);
      end else if (pick < 89) begin
         dev = cur_dev + $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
         arr = cur_arr + {$urandom_range(0, 255), $urandom};
      end else if (pick < 94) begin
         arr = cur_arr - {$urandom_range(0, 15), $urandom};
      end else begin
         dev = $urandom;
         arr = {$urandom, $urandom};
      end
      send_stamp(dev, arr[62:0]);
   endtask

   initial begin
      sb = new();
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.device_time_ms  <= '0;
      req_bus.host_arrival_ns <= '0;
      csr_we                  <= 1'b0;
      csr_index               <= CSR_WINDOW;
      csr_wdata               <= '0;
      cur_dev       = '0;
      cur_arr       = '0;
      cur_window    = 32'(WINDOW_RST);
      settings      = 0;
      src_idling    = 1'b1;
      sink_idling   = 1'b1;
      sink_hold_req = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings
      send_stamp(32'd0, 63'd0);
      send_stamp(32'd0, 63'd5);
      send_stamp(32'd10, 63'd10_000_000);
      send_stamp(32'd20, 63'd30_000_000);
      send_stamp(32'd20, 63'd15_000_000);
      send_stamp(32'd1020, 63'd1_050_000_000);
      send_stamp(32'd1500, 63'd1_000_000_000);
      send_stamp(32'd2100, 63'd1_200_000_000);
      send_stamp(32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
      // arrival far behind the anchor at a calibration point
      send_stamp(32'd1499, 63'd1000);
      send_stamp(32'd1499 + HALF_RANGE_DEF, 63'd5_000_000_000);
      send_stamp(cur_dev + (HALF_RANGE_DEF - 32'd1), 63'd5_000_000_001);
      send_stamp(cur_dev - 32'd1, 63'd1_000_000_000);
      // saturating observed rate
      send_stamp(cur_dev + 32'd1000, 63'h7FFF_FFFF_FFFF_FFFF);
      send_stamp(cur_dev, 63'h7FFF_FFFF_FFFF_FFFF);
      send_stamp(cur_dev, 63'd7);
      wait_drained();

      // directed: zero window, widest clamps, full blend
      program_settings(32'h0000_0000, 32'h0000_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_stamp(cur_dev - 32'd1, 63'd2_000_000_000);
      send_stamp(cur_dev + 32'd1, 63'd2_001_000_000);
      send_stamp(cur_dev + 32'd2, 63'd2_004_000_000);
      send_stamp(cur_dev + 32'd1, 63'd2_004_100_000);
      wait_drained();

      // directed: accumulator wraps to zero exactly at a calibration point
      program_settings(32'hA5A5_0002, 32'h5A5A_8000, 32'h3000_0000, 32'h5000_0000);
      send_stamp(cur_dev - 32'd1, 63'd3_000_000_000);
      send_stamp(cur_dev + 32'h7FFF_FFFF, 63'(cur_arr + 64'd1_000_000_000_000));
      send_stamp(cur_dev + 32'h7FFF_FFFF, 63'(cur_arr + 64'd1_000_000_000_000));
      send_stamp(cur_dev + 32'd2, 63'(cur_arr + 64'd2_000_000));
      wait_drained();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0:       program_settings(32'd50, 32'd20000, 32'h5000_0000, 32'h3000_0000);
            1:       program_settings(32'd65535, 32'd0, 32'h4000_0000, 32'h4000_0000);
            default: random_settings();
         endcase
         src_idling  = (ph != PHASE_COUNT - 1);
         sink_idling = (ph != PHASE_COUNT - 1);
         // starve the response side while stamps keep coming
         if (ph == 2) sink_hold_req = 1'b1;
         repeat (PHASE_ITEMS) random_item();
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d stamps under %0d register settings beyond reset.", sb.stamps,
               settings);
      $display("Mapping restarted %0d times and recalibrated %0d times.", sb.restarts,
               sb.recalibrations);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### files.f
rtl/dchtm_pkg.sv
rtl/dchtm_if.sv
rtl/dchtm_ctrl.sv
rtl/dchtm_dp.sv
rtl/device_clock_to_host_time_mapper.sv
bench/device_clock_to_host_time_mapper_tb.sv
